/* design/plds_pkg.sv */
// Package for the power-cosine lobe direction sampler.
// Holds default widths, fixed-point formats and elaboration-time constant functions.
// No dependencies.
`default_nettype none

package plds_pkg;

  // Default widths of the stream fields.
  localparam int unsigned SAMPLE_BITS_DEF   = 16;
  localparam int unsigned OUT_BITS_DEF      = 16;
  localparam int unsigned EXPONENT_BITS_DEF = 10;

  // Log of the elevation sample: U1.30 mantissa, 24 fraction bits.
  localparam int unsigned LOG_FRAC = 24;
  localparam int unsigned MANT_W   = 31;

  // Power stage: U1.32 value, one cell per fraction bit of the quotient.
  localparam int unsigned ROOT_W    = 33;
  localparam int unsigned FACTOR_W  = 32;
  localparam int unsigned POW_STEPS = LOG_FRAC;

  // Square root of a value below 2^61, one result bit per cell.
  localparam int unsigned SQRT_STEPS = 31;
  localparam int unsigned SQRT_W     = 62;

  // Angle in U1.30, Taylor sums with seven terms after the first.
  localparam int unsigned ANG_W     = 31;
  localparam int unsigned TAY_W     = 32;
  localparam int unsigned TAY_STEPS = 7;
  localparam logic [ANG_W-1:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [ANG_W-1:0] ONE_Q30     = 31'h4000_0000;

  // Floor square root of a 64-bit value, elaboration use only.
  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] rest;
    logic [63:0] root;
    logic [63:0] bitv;
    rest = x;
    root = '0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rest >= root + bitv) begin
        rest = rest - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // 2^(-2^-idx) in U0.32, each factor the floor root of the one before it.
  function automatic logic [FACTOR_W-1:0] pow_factor(input int unsigned idx);
    logic [63:0] c;
    c = isqrt64(64'd1 << 63);
    for (int unsigned j = 1; j < idx; j++) begin
      c = isqrt64(c << 32);
    end
    return c[FACTOR_W-1:0];
  endfunction

  // Divisor (n+1)(n+2) of a Taylor step; first is 1 for sine and 0 for cosine.
  function automatic int unsigned taylor_div(input int unsigned first, input int unsigned step);
    int unsigned n;
    n = first + 2 * step;
    return (n + 1) * (n + 2);
  endfunction

endpackage

`default_nettype wire

/* design/plds_if.sv */
// Stream interfaces of the lobe direction sampler: sample transactions in,
// direction transactions out. Depends on plds_pkg for default widths.
`default_nettype none

interface plds_in_if #(
  parameter int unsigned SAMPLE_BITS   = plds_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned EXPONENT_BITS = plds_pkg::EXPONENT_BITS_DEF
) ();
  logic                     valid;
  logic                     ready;
  logic [SAMPLE_BITS-1:0]   elevation_sample;
  logic [SAMPLE_BITS-1:0]   azimuth_sample;
  logic [EXPONENT_BITS-1:0] lobe_exponent;

  modport source (output valid, output elevation_sample, output azimuth_sample,
                  output lobe_exponent, input ready);
  modport sink   (input valid, input elevation_sample, input azimuth_sample,
                  input lobe_exponent, output ready);
endinterface

interface plds_out_if #(
  parameter int unsigned OUT_BITS = plds_pkg::OUT_BITS_DEF
) ();
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] dir_x;
  logic signed [OUT_BITS-1:0] dir_y;
  logic [OUT_BITS-2:0]        dir_z;

  modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
  modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

`default_nettype wire

/* design/plds_log_cell.sv */
// One cell of the log chain: square the U1.30 mantissa, emit one log fraction bit.
// Depends on plds_pkg.
`default_nettype none

module plds_log_cell #(
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic                                clk_i,
  input  wire logic                                en_i,
  input  wire logic [plds_pkg::MANT_W-1:0]         m_i,
  input  wire logic [plds_pkg::LOG_FRAC-1:0]       frac_i,
  input  wire logic [SIDE_W-1:0]                   side_i,
  output logic      [plds_pkg::MANT_W-1:0]         m_o,
  output logic      [plds_pkg::LOG_FRAC-1:0]       frac_o,
  output logic      [SIDE_W-1:0]                   side_o
);

  logic [2*plds_pkg::MANT_W-1:0] sq;
  logic [plds_pkg::MANT_W:0]     sq_hi;
  logic [plds_pkg::MANT_W-1:0]   m_d;
  logic                          bit_d;

  assign sq    = (2*plds_pkg::MANT_W)'(m_i) * (2*plds_pkg::MANT_W)'(m_i);
  assign sq_hi = sq[2*plds_pkg::MANT_W-1:plds_pkg::MANT_W-1];
  assign bit_d = sq_hi[plds_pkg::MANT_W];
  // renormalize into [1,2) when the square reached 2
  assign m_d   = bit_d ? sq_hi[plds_pkg::MANT_W:1] : sq_hi[plds_pkg::MANT_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_o    <= m_d;
      frac_o <= {frac_i[plds_pkg::LOG_FRAC-2:0], bit_d};
      side_o <= side_i;
    end
  end

endmodule

`default_nettype wire

/* design/plds_div_cell.sv */
// One cell of the restoring divider: one quotient bit per cell, MSB first.
// Depends on nothing outside itself.
`default_nettype none

module plds_div_cell #(
  parameter int unsigned NUM_W  = 29,
  parameter int unsigned DIV_W  = 11,
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [NUM_W-1:0]  num_i,
  input  wire logic [DIV_W-1:0]  rem_i,
  input  wire logic [NUM_W-1:0]  quo_i,
  input  wire logic [DIV_W-1:0]  div_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic      [NUM_W-1:0]  num_o,
  output logic      [DIV_W-1:0]  rem_o,
  output logic      [NUM_W-1:0]  quo_o,
  output logic      [DIV_W-1:0]  div_o,
  output logic      [SIDE_W-1:0] side_o
);

  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             ge;
  logic [DIV_W-1:0] rem_d;

  assign trial = {rem_i, num_i[NUM_W-1]};
  assign diff  = trial - {1'b0, div_i};
  assign ge    = trial >= {1'b0, div_i};
  assign rem_d = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_o  <= {num_i[NUM_W-2:0], 1'b0};
      rem_o  <= rem_d;
      quo_o  <= {quo_i[NUM_W-2:0], ge};
      div_o  <= div_i;
      side_o <= side_i;
    end
  end

endmodule

`default_nettype wire

/* design/plds_pow_cell.sv */
// One cell of the power chain: multiply by 2^(-2^-IDX) when that quotient bit is set.
// Depends on plds_pkg for the factor table.
`default_nettype none

module plds_pow_cell #(
  parameter int unsigned IDX    = 1,
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic                            clk_i,
  input  wire logic                            en_i,
  input  wire logic [plds_pkg::ROOT_W-1:0]     r_i,
  input  wire logic [plds_pkg::LOG_FRAC-1:0]   f_i,
  input  wire logic [SIDE_W-1:0]               side_i,
  output logic      [plds_pkg::ROOT_W-1:0]     r_o,
  output logic      [plds_pkg::LOG_FRAC-1:0]   f_o,
  output logic      [SIDE_W-1:0]               side_o
);

  localparam int unsigned PW = plds_pkg::ROOT_W + plds_pkg::FACTOR_W;
  localparam logic [plds_pkg::FACTOR_W-1:0] FACTOR = plds_pkg::pow_factor(IDX);

  logic [PW-1:0] prod;

  assign prod = PW'(r_i) * PW'(FACTOR);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_o    <= f_i[plds_pkg::LOG_FRAC-IDX] ? prod[PW-1:plds_pkg::FACTOR_W] : r_i;
      f_o    <= f_i;
      side_o <= side_i;
    end
  end

endmodule

`default_nettype wire

/* design/plds_sqrt_cell.sv */
// One cell of the digit-by-digit square root: settles the result bit of weight 2^IDX.
// Depends on plds_pkg.
`default_nettype none

module plds_sqrt_cell #(
  parameter int unsigned IDX    = 0,
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [plds_pkg::SQRT_W-1:0]   x_i,
  input  wire logic [plds_pkg::SQRT_W-1:0]   r_i,
  input  wire logic [SIDE_W-1:0]             side_i,
  output logic      [plds_pkg::SQRT_W-1:0]   x_o,
  output logic      [plds_pkg::SQRT_W-1:0]   r_o,
  output logic      [SIDE_W-1:0]             side_o
);

  localparam logic [plds_pkg::SQRT_W-1:0] BITV = plds_pkg::SQRT_W'(1) << (2 * IDX);

  logic [plds_pkg::SQRT_W-1:0] trial;
  logic                        ge;

  assign trial = r_i + BITV;
  assign ge    = x_i >= trial;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o    <= ge ? x_i - trial : x_i;
      r_o    <= ge ? (r_i >> 1) + BITV : r_i >> 1;
      side_o <= side_i;
    end
  end

endmodule

`default_nettype wire

/* design/plds_taylor_cell.sv */
// One Taylor term cell: term*t^2, divide by the constant (n+1)(n+2) through a
// reciprocal with one correction, then add or subtract. Three register stages.
// Depends on plds_pkg.
`default_nettype none

module plds_taylor_cell #(
  parameter int unsigned DIVISOR  = 2,
  parameter bit          SUBTRACT = 1'b1
) (
  input  wire logic                         clk_i,
  input  wire logic                         en_i,
  input  wire logic [plds_pkg::TAY_W-1:0]   t2_i,
  input  wire logic [plds_pkg::TAY_W-1:0]   term_i,
  input  wire logic [plds_pkg::TAY_W-1:0]   sum_i,
  output logic      [plds_pkg::TAY_W-1:0]   t2_o,
  output logic      [plds_pkg::TAY_W-1:0]   term_o,
  output logic      [plds_pkg::TAY_W-1:0]   sum_o
);

  localparam int unsigned W  = plds_pkg::TAY_W;
  localparam logic [W-1:0] RECIP = W'((64'd1 << W) / DIVISOR);
  localparam logic [W-1:0] DIVV  = W'(DIVISOR);

  logic [2*W-1:0] mul_a;
  logic [W-1:0]   a_x_q, a_sum_q, a_t2_q;
  logic [2*W-1:0] mul_b;
  logic [W-1:0]   b_qp_q, b_x_q, b_sum_q, b_t2_q;
  logic [2*W-1:0] back;
  logic [W-1:0]   resid;
  logic [W-1:0]   quo;
  logic [W-1:0]   sum_d;

  // term * t^2 in U2.30; the value stays below 2^32
  assign mul_a = (2*W)'(term_i) * (2*W)'(t2_i);
  // quotient estimate, at most one short
  assign mul_b = (2*W)'(a_x_q) * (2*W)'(RECIP);
  assign back  = (2*W)'(b_qp_q) * (2*W)'(DIVV);
  assign resid = b_x_q - back[W-1:0];
  assign quo   = b_qp_q + W'(resid >= DIVV);

  always_comb begin
    if (SUBTRACT) begin
      sum_d = (b_sum_q >= quo) ? b_sum_q - quo : '0;
    end else begin
      sum_d = b_sum_q + quo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_x_q   <= mul_a[W+29:30];
      a_sum_q <= sum_i;
      a_t2_q  <= t2_i;
      b_qp_q  <= mul_b[2*W-1:W];
      b_x_q   <= a_x_q;
      b_sum_q <= a_sum_q;
      b_t2_q  <= a_t2_q;
      term_o  <= quo;
      sum_o   <= sum_d;
      t2_o    <= b_t2_q;
    end
  end

endmodule

`default_nettype wire

/* design/phong_lobe_direction_sampler_top.sv */
// Top level of the power-cosine lobe direction sampler.
// Depends on plds_pkg, plds_if and the plds_*_cell modules.
//
//   channel | dir | fields                                          | handshake
//   in_i    | in  | elevation_sample, azimuth_sample, lobe_exponent | valid/ready
//   out_o   | out | dir_x, dir_y, dir_z                             | valid/ready
//
// One transaction enters per cycle while the output is not stalled. A result
// passes the input register, the cell chains (log squaring, divider, power,
// square root) with the cos(el) registers between the last two, and the
// product and output registers on its way from accept to result.
// Reset clears the stage valid bits and the output valid; payload is not reset.
// All stages move on one enable; a bubble in the last stage lets the chain
// advance while a finished result waits at the output.
`default_nettype none

module phong_lobe_direction_sampler_top #(
  parameter int unsigned SAMPLE_BITS   = plds_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned OUT_BITS      = plds_pkg::OUT_BITS_DEF,
  parameter int unsigned EXPONENT_BITS = plds_pkg::EXPONENT_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  plds_in_if.sink   in_i,
  plds_out_if.source out_o
);

  localparam int unsigned LF    = plds_pkg::LOG_FRAC;
  localparam int unsigned MW    = plds_pkg::MANT_W;
  localparam int unsigned RW    = plds_pkg::ROOT_W;
  localparam int unsigned QW2   = plds_pkg::SQRT_W;
  localparam int unsigned AW    = plds_pkg::ANG_W;
  localparam int unsigned TW    = plds_pkg::TAY_W;
  localparam int unsigned TS    = plds_pkg::TAY_STEPS;
  localparam int unsigned PW    = $clog2(SAMPLE_BITS);
  localparam int unsigned SPW   = $clog2(SAMPLE_BITS + 1);
  localparam int unsigned LGW   = SPW + LF;
  localparam int unsigned DW    = EXPONENT_BITS + 1;
  localparam int unsigned RMW   = SAMPLE_BITS - 2;
  localparam int unsigned ZW    = OUT_BITS - 1;
  localparam int unsigned TPW   = SAMPLE_BITS + 29;
  localparam int unsigned LSW   = DW + 1 + PW;
  localparam int unsigned PSW   = 1 + SPW;
  localparam int unsigned E     = LF + LGW + plds_pkg::POW_STEPS + 2 + plds_pkg::SQRT_STEPS;
  localparam int unsigned AZ_PRE = 2 + 3 * TS;
  localparam int unsigned AZ_LAT = AZ_PRE + 1;
  localparam int unsigned AZ_DLY = E - AZ_LAT;
  localparam int unsigned NV    = E + 2;
  localparam int unsigned SH    = 61 - OUT_BITS;

  localparam logic [1:0] QUAD_FIRST  = 2'd0;
  localparam logic [1:0] QUAD_SECOND = 2'd1;
  localparam logic [1:0] QUAD_THIRD  = 2'd2;
  localparam logic [1:0] QUAD_FOURTH = 2'd3;

  typedef struct packed {
    logic [AW-1:0] ca;
    logic [AW-1:0] sa;
    logic          nca;
    logic          nsa;
  } az_t;

  // ---------------------------------------------------------------- flow control
  logic          en;
  logic          accept;
  logic [NV-1:0] v_q;
  logic          out_valid_q;

  assign en         = !v_q[NV-1] || !out_valid_q || out_o.ready;
  assign in_i.ready = en;
  assign accept     = in_i.valid && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (en) begin
        v_q <= {v_q[NV-2:0], accept};
      end
      if (en && v_q[NV-1]) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- input stage
  // Normalize u1 to a U1.30 mantissa by its leading one; split u2 into quadrant
  // and remainder.
  logic [PW-1:0]                lead_c;
  logic [SAMPLE_BITS+29:0]      wide_c;
  logic [LSW-1:0]               log_side [0:LF];
  logic [MW-1:0]                log_m    [0:LF];
  logic [LF-1:0]                log_frac [0:LF];
  logic [RMW-1:0]               rem_q;
  logic [1:0]                   quad_q   [0:AZ_PRE];

  always_comb begin
    lead_c = '0;
    for (int i = 0; i < SAMPLE_BITS; i++) begin
      if (in_i.elevation_sample[i]) begin
        lead_c = PW'(i);
      end
    end
  end

  assign wide_c = {in_i.elevation_sample, 30'b0} >> lead_c;

  always_ff @(posedge clk_i) begin
    if (en) begin
      log_m[0]    <= wide_c[MW-1:0];
      log_frac[0] <= '0;
      log_side[0] <= {DW'(in_i.lobe_exponent) + DW'(1),
                      in_i.elevation_sample == '0, lead_c};
      rem_q       <= in_i.azimuth_sample[RMW-1:0];
    end
  end

  // ---------------------------------------------------------------- log chain
  for (genvar g = 0; g < LF; g++) begin : g_log
    plds_log_cell #(.SIDE_W(LSW)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .m_i    (log_m[g]),
      .frac_i (log_frac[g]),
      .side_i (log_side[g]),
      .m_o    (log_m[g+1]),
      .frac_o (log_frac[g+1]),
      .side_o (log_side[g+1])
    );
  end

  // -log2(u1) in U(SPW).24
  logic [SPW-1:0] int_c;
  logic [LGW-1:0] lg_c;

  assign int_c = SPW'(SAMPLE_BITS) - SPW'(log_side[LF][PW-1:0]);
  assign lg_c  = {int_c, {LF{1'b0}}} - {{SPW{1'b0}}, log_frac[LF]};

  // ---------------------------------------------------------------- divider chain
  logic [LGW-1:0] div_num  [0:LGW];
  logic [DW-1:0]  div_rem  [0:LGW];
  logic [LGW-1:0] div_quo  [0:LGW];
  logic [DW-1:0]  div_d    [0:LGW];
  logic           div_zero [0:LGW];

  assign div_num[0]  = lg_c;
  assign div_rem[0]  = '0;
  assign div_quo[0]  = '0;
  assign div_d[0]    = log_side[LF][LSW-1:PW+1];
  assign div_zero[0] = log_side[LF][PW];

  for (genvar g = 0; g < LGW; g++) begin : g_div
    plds_div_cell #(.NUM_W(LGW), .DIV_W(DW), .SIDE_W(1)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (div_num[g]),
      .rem_i  (div_rem[g]),
      .quo_i  (div_quo[g]),
      .div_i  (div_d[g]),
      .side_i (div_zero[g]),
      .num_o  (div_num[g+1]),
      .rem_o  (div_rem[g+1]),
      .quo_o  (div_quo[g+1]),
      .div_o  (div_d[g+1]),
      .side_o (div_zero[g+1])
    );
  end

  // ---------------------------------------------------------------- power chain
  // Integer part of the quotient becomes a right shift at the end.
  logic [RW-1:0]  pow_r    [0:plds_pkg::POW_STEPS];
  logic [LF-1:0]  pow_f    [0:plds_pkg::POW_STEPS];
  logic [PSW-1:0] pow_side [0:plds_pkg::POW_STEPS];

  assign pow_r[0]    = RW'(1) << 32;
  assign pow_f[0]    = div_quo[LGW][LF-1:0];
  assign pow_side[0] = {div_zero[LGW], div_quo[LGW][LGW-1:LF]};

  for (genvar g = 0; g < plds_pkg::POW_STEPS; g++) begin : g_pow
    plds_pow_cell #(.IDX(g + 1), .SIDE_W(PSW)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .r_i    (pow_r[g]),
      .f_i    (pow_f[g]),
      .side_i (pow_side[g]),
      .r_o    (pow_r[g+1]),
      .f_o    (pow_f[g+1]),
      .side_o (pow_side[g+1])
    );
  end

  // ---------------------------------------------------------------- cos(el) stages
  logic [RW-1:0]    cz_c;
  logic [AW-1:0]    c30_c;
  logic [RW:0]      zsum_c;
  logic [RW:0]      zsh_c;
  logic [ZW-1:0]    z_c;
  logic [AW-1:0]    p_c30_q;
  logic [ZW-1:0]    p_z_q;
  logic [2*AW-1:0]  c_sq;
  logic [QW2-1:0]   q_rad_q;
  logic [ZW-1:0]    q_z_q;

  assign cz_c   = pow_side[plds_pkg::POW_STEPS][PSW-1] ? '0 :
                  pow_r[plds_pkg::POW_STEPS] >> pow_side[plds_pkg::POW_STEPS][SPW-1:0];
  assign c30_c  = (cz_c[RW-1:2] > plds_pkg::ONE_Q30) ? plds_pkg::ONE_Q30 : cz_c[RW-1:2];
  assign zsum_c = {1'b0, cz_c} + ((RW + 1)'(1) << (32 - OUT_BITS));
  assign zsh_c  = zsum_c >> (33 - OUT_BITS);
  assign z_c    = (zsh_c > (RW + 1)'({ZW{1'b1}})) ? {ZW{1'b1}} : zsh_c[ZW-1:0];
  assign c_sq   = (2*AW)'(p_c30_q) * (2*AW)'(p_c30_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_c30_q <= c30_c;
      p_z_q   <= z_c;
      q_rad_q <= (QW2'(1) << 60) - QW2'(c_sq);
      q_z_q   <= p_z_q;
    end
  end

  // ---------------------------------------------------------------- square root chain
  logic [QW2-1:0] sq_x    [0:plds_pkg::SQRT_STEPS];
  logic [QW2-1:0] sq_r    [0:plds_pkg::SQRT_STEPS];
  logic [ZW-1:0]  sq_side [0:plds_pkg::SQRT_STEPS];

  assign sq_x[0]    = q_rad_q;
  assign sq_r[0]    = '0;
  assign sq_side[0] = q_z_q;

  for (genvar g = 0; g < plds_pkg::SQRT_STEPS; g++) begin : g_sqrt
    plds_sqrt_cell #(.IDX(plds_pkg::SQRT_STEPS - 1 - g), .SIDE_W(ZW)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .x_i    (sq_x[g]),
      .r_i    (sq_r[g]),
      .side_i (sq_side[g]),
      .x_o    (sq_x[g+1]),
      .r_o    (sq_r[g+1]),
      .side_o (sq_side[g+1])
    );
  end

  logic [AW-1:0] se_c;

  assign se_c = (sq_r[plds_pkg::SQRT_STEPS] > QW2'(plds_pkg::ONE_Q30)) ?
                plds_pkg::ONE_Q30 : sq_r[plds_pkg::SQRT_STEPS][AW-1:0];

  // ---------------------------------------------------------------- azimuth path
  logic [TPW-1:0]  t_prod;
  logic [AW-1:0]   t_q;
  logic [2*AW-1:0] t_sq;
  logic [TW-1:0]   t2_q;
  logic [TW-1:0]   ts_q;
  logic [TW-1:0]   sin_t2 [0:TS], sin_term [0:TS], sin_sum [0:TS];
  logic [TW-1:0]   cos_t2 [0:TS], cos_term [0:TS], cos_sum [0:TS];

  assign t_prod = TPW'(rem_q) * TPW'(plds_pkg::HALF_PI_Q30);
  assign t_sq   = (2*AW)'(t_q) * (2*AW)'(t_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q       <= t_prod[RMW +: AW];
      t2_q      <= t_sq[2*AW-1:30];
      ts_q      <= TW'(t_q);
      quad_q[0] <= in_i.azimuth_sample[SAMPLE_BITS-1:SAMPLE_BITS-2];
      for (int i = 1; i <= AZ_PRE; i++) begin
        quad_q[i] <= quad_q[i-1];
      end
    end
  end

  assign sin_t2[0]   = t2_q;
  assign sin_term[0] = ts_q;
  assign sin_sum[0]  = ts_q;
  assign cos_t2[0]   = t2_q;
  assign cos_term[0] = TW'(plds_pkg::ONE_Q30);
  assign cos_sum[0]  = TW'(plds_pkg::ONE_Q30);

  for (genvar g = 0; g < TS; g++) begin : g_tay
    plds_taylor_cell #(
      .DIVISOR  (plds_pkg::taylor_div(1, g)),
      .SUBTRACT ((g % 2) == 0)
    ) u_sin (
      .clk_i  (clk_i),
      .en_i   (en),
      .t2_i   (sin_t2[g]),
      .term_i (sin_term[g]),
      .sum_i  (sin_sum[g]),
      .t2_o   (sin_t2[g+1]),
      .term_o (sin_term[g+1]),
      .sum_o  (sin_sum[g+1])
    );
    plds_taylor_cell #(
      .DIVISOR  (plds_pkg::taylor_div(0, g)),
      .SUBTRACT ((g % 2) == 0)
    ) u_cos (
      .clk_i  (clk_i),
      .en_i   (en),
      .t2_i   (cos_t2[g]),
      .term_i (cos_term[g]),
      .sum_i  (cos_sum[g]),
      .t2_o   (cos_t2[g+1]),
      .term_o (cos_term[g+1]),
      .sum_o  (cos_sum[g+1])
    );
  end

  // Clamp the sums to 1.0 and fold the quadrant into swaps and signs.
  logic [AW-1:0] s0_c, c0_c;
  az_t           az_c;
  az_t           az_q [0:AZ_DLY];

  assign s0_c = (sin_sum[TS] > TW'(plds_pkg::ONE_Q30)) ? plds_pkg::ONE_Q30 : sin_sum[TS][AW-1:0];
  assign c0_c = (cos_sum[TS] > TW'(plds_pkg::ONE_Q30)) ? plds_pkg::ONE_Q30 : cos_sum[TS][AW-1:0];

  always_comb begin
    unique case (quad_q[AZ_PRE])
      QUAD_FIRST:  az_c = '{ca: c0_c, sa: s0_c, nca: 1'b0, nsa: 1'b0};
      QUAD_SECOND: az_c = '{ca: s0_c, sa: c0_c, nca: 1'b1, nsa: 1'b0};
      QUAD_THIRD:  az_c = '{ca: c0_c, sa: s0_c, nca: 1'b1, nsa: 1'b1};
      QUAD_FOURTH: az_c = '{ca: s0_c, sa: c0_c, nca: 1'b0, nsa: 1'b1};
      default:     az_c = '{ca: c0_c, sa: s0_c, nca: 1'b0, nsa: 1'b0};
    endcase
  end

  // Hold the azimuth terms until sin(el) catches up.
  always_ff @(posedge clk_i) begin
    if (en) begin
      az_q[0] <= az_c;
      for (int i = 1; i <= AZ_DLY; i++) begin
        az_q[i] <= az_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------- products
  logic [2*AW-1:0] m_px_q, m_py_q;
  logic            m_nx_q, m_ny_q;
  logic [ZW-1:0]   m_z_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_px_q <= (2*AW)'(az_q[AZ_DLY].ca) * (2*AW)'(se_c);
      m_py_q <= (2*AW)'(az_q[AZ_DLY].sa) * (2*AW)'(se_c);
      m_nx_q <= az_q[AZ_DLY].nca;
      m_ny_q <= az_q[AZ_DLY].nsa;
      m_z_q  <= sq_side[plds_pkg::SQRT_STEPS];
    end
  end

  // ---------------------------------------------------------------- output register
  // Round half up to Q1.(OUT_BITS-1), saturate, negate the magnitude when its sign flag is set.
  logic [2*AW:0]       rx_c, ry_c;
  logic [ZW-1:0]       magx_c, magy_c;
  logic [OUT_BITS-1:0] ox_c, oy_c;
  logic [OUT_BITS-1:0] dir_x_q, dir_y_q;
  logic [ZW-1:0]       dir_z_q;

  assign rx_c   = ({1'b0, m_px_q} + ((2*AW + 1)'(1) << (SH - 1))) >> SH;
  assign ry_c   = ({1'b0, m_py_q} + ((2*AW + 1)'(1) << (SH - 1))) >> SH;
  assign magx_c = (rx_c > (2*AW + 1)'({ZW{1'b1}})) ? {ZW{1'b1}} : rx_c[ZW-1:0];
  assign magy_c = (ry_c > (2*AW + 1)'({ZW{1'b1}})) ? {ZW{1'b1}} : ry_c[ZW-1:0];
  assign ox_c   = m_nx_q ? OUT_BITS'(0) - {1'b0, magx_c} : {1'b0, magx_c};
  assign oy_c   = m_ny_q ? OUT_BITS'(0) - {1'b0, magy_c} : {1'b0, magy_c};

  always_ff @(posedge clk_i) begin
    if (en && v_q[NV-1]) begin
      dir_x_q <= ox_c;
      dir_y_q <= oy_c;
      dir_z_q <= m_z_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.dir_x = dir_x_q;
  assign out_o.dir_y = dir_y_q;
  assign out_o.dir_z = dir_z_q;

  // ---------------------------------------------------------------- assertions
`ifndef ASSERT_OFF
  // A finished item must not overrun a result that still waits.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready && v_q[NV-1]) |-> !in_i.ready)
    else $error("pipeline advanced over a waiting result");

  // A new result only comes out of the last stage.
  a_rise_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(v_q[NV-1]))
    else $error("output valid without a finished item");

  // Saturated negation never yields the most negative code.
  a_no_min_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (dir_x_q != {1'b1, {ZW{1'b0}}}) && (dir_y_q != {1'b1, {ZW{1'b0}}}))
    else $error("direction component at most negative code");
`endif

endmodule

`default_nettype wire

/* tb/phong_lobe_direction_sampler_top_tb.sv */
// Self-checking testbench for phong_lobe_direction_sampler_top.
// Drives sample transactions through plds_in_if and checks each direction from
// plds_out_if against a bit-accurate predictor or a direction typed in by hand. Depends on plds_pkg and plds_if.
`timescale 1ns / 100ps

module phong_lobe_direction_sampler_top_tb;
  import plds_pkg::*;

  localparam int unsigned SB = SAMPLE_BITS_DEF;
  localparam int unsigned OB = OUT_BITS_DEF;
  localparam int unsigned EB = EXPONENT_BITS_DEF;
  localparam int unsigned N_RANDOM = 1400;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = 300;

  typedef struct packed {
    logic [SB-1:0] elev;
    logic [SB-1:0] azim;
    logic [EB-1:0] expo;
  } sample_t;

  typedef struct packed {
    logic [OB-1:0] x;
    logic [OB-1:0] y;
    logic [OB-2:0] z;
  } direction_t;

  // One row of the directed table; has_dir marks a direction typed in by hand.
  typedef struct packed {
    sample_t    smp;
    logic       has_dir;
    direction_t dir;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  plds_in_if  #(.SAMPLE_BITS(SB), .EXPONENT_BITS(EB)) in_ch ();
  plds_out_if #(.OUT_BITS(OB)) out_ch ();

  phong_lobe_direction_sampler_top #(
    .SAMPLE_BITS(SB), .OUT_BITS(OB), .EXPONENT_BITS(EB)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  direction_t pending_dirs[$];
  int unsigned error_count;
  int unsigned idle_cycles;
  bit          stim_done;
  bit          stall_enable;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor: integer square root, power-cosine root and Taylor sums, all at
  // the block's fixed-point formats.
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] floor_sqrt(input logic [63:0] val);
    logic [63:0] rest, root, bitv;
    rest = val;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > rest && bitv != 0) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rest >= root + bitv) begin
        rest = rest - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // u^(1/div) in U1.32
  function automatic logic [63:0] lobe_root(input logic [63:0] u, input logic [63:0] div);
    int lead;
    logic [63:0] mant, frac, lg, quo, ip, fp, acc, fac;
    lead = 0;
    frac = '0;
    if (u == 0) return 64'd0;
    for (int i = 0; i < 63; i++) if (u[i]) lead = i;
    mant = (lead <= 30) ? (u << (30 - lead)) : (u >> (lead - 30));
    for (int i = 0; i < LOG_FRAC; i++) begin
      mant = (mant * mant) >> 30;
      frac = frac << 1;
      if (mant >= (64'd2 << 30)) begin
        frac[0] = 1'b1;
        mant = mant >> 1;
      end
    end
    lg = ((64'(SB) - 64'(lead)) << LOG_FRAC) - frac;
    quo = lg / div;
    ip = quo >> LOG_FRAC;
    fp = quo & ((64'd1 << LOG_FRAC) - 1);
    acc = 64'd1 << 32;
    fac = floor_sqrt(64'd1 << 63);
    for (int i = 1; i <= LOG_FRAC; i++) begin
      if (fp[LOG_FRAC-i]) acc = (acc * fac) >> 32;
      fac = floor_sqrt(fac << 32);
    end
    return (ip >= 40) ? 64'd0 : (acc >> ip);
  endfunction

  function automatic logic [63:0] taylor_sum(input logic [63:0] t2, input logic [63:0] start,
                                             input int unsigned first);
    logic [63:0] sum, term;
    int unsigned k;
    bit subtract;
    sum = start;
    term = start;
    k = first;
    subtract = 1'b1;
    while (k + 2 <= 15) begin
      term = (term * t2) >> 30;
      term = term / (64'(k + 1) * 64'(k + 2));
      if (subtract) sum = (sum >= term) ? sum - term : 64'd0;
      else sum = sum + term;
      subtract = !subtract;
      k += 2;
    end
    return (sum > 64'(ONE_Q30)) ? 64'(ONE_Q30) : sum;
  endfunction

  // Round a Q.60 product to OB-1 fraction bits, saturate, apply the sign.
  function automatic logic [OB-1:0] scaled_component(input logic [63:0] a,
                                                     input logic [63:0] b, input bit neg);
    logic [63:0] v;
    v = (a * b + (64'd1 << (60 - OB))) >> (61 - OB);
    if (v > ((64'd1 << (OB - 1)) - 1)) v = (64'd1 << (OB - 1)) - 1;
    return neg ? OB'(-v) : OB'(v);
  endfunction

  function automatic direction_t predict_direction(input sample_t s);
    logic [63:0] cz, c30, se, zz, rem, t, t2, s0, c0, ca, sa;
    logic [1:0] quad;
    bit nca, nsa;
    direction_t d;
    cz = lobe_root(64'(s.elev), 64'(s.expo) + 1);
    c30 = cz >> 2;
    if (c30 > 64'(ONE_Q30)) c30 = 64'(ONE_Q30);
    se = floor_sqrt((64'd1 << 60) - c30 * c30);
    if (se > 64'(ONE_Q30)) se = 64'(ONE_Q30);
    zz = (cz + (64'd1 << (32 - OB))) >> (33 - OB);
    if (zz > ((64'd1 << (OB - 1)) - 1)) zz = (64'd1 << (OB - 1)) - 1;
    quad = s.azim[SB-1 -: 2];
    rem = 64'(s.azim[SB-3:0]);
    t = (rem * 64'(HALF_PI_Q30)) >> (SB - 2);
    t2 = (t * t) >> 30;
    s0 = taylor_sum(t2, t, 1);
    c0 = taylor_sum(t2, 64'(ONE_Q30), 0);
    case (quad)
      2'd0: begin ca = c0; sa = s0; nca = 0; nsa = 0; end
      2'd1: begin ca = s0; sa = c0; nca = 1; nsa = 0; end
      2'd2: begin ca = c0; sa = s0; nca = 1; nsa = 1; end
      default: begin ca = s0; sa = c0; nca = 0; nsa = 1; end
    endcase
    d.x = scaled_component(ca, se, nca);
    d.y = scaled_component(sa, se, nsa);
    d.z = zz[OB-2:0];
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: drive one transaction, or hold valid low for an optional gap.
  // ---------------------------------------------------------------------------
  task automatic send_sample(input sample_t s, input direction_t d, input bit typed);
    in_ch.valid            <= 1'b1;
    in_ch.elevation_sample <= s.elev;
    in_ch.azimuth_sample   <= s.azim;
    in_ch.lobe_exponent    <= s.expo;
    // Queue the expectation before the handshake can complete.
    pending_dirs.push_back(typed ? d : predict_direction(s));
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic idle_gap(input int unsigned cycles);
    if (cycles != 0) begin
      in_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  function automatic sample_t random_sample();
    sample_t s;
    int unsigned pick;
    s.elev = SB'($urandom);
    s.azim = SB'($urandom);
    pick = $urandom_range(0, 9);
    // Mostly small exponents, with the full range and its extremes mixed in.
    if (pick < 5) s.expo = EB'($urandom_range(0, 64));
    else if (pick < 8) s.expo = EB'($urandom);
    else if (pick == 8) s.expo = {EB{1'b1}};
    else s.expo = '0;
    if ($urandom_range(0, 15) == 0) s.elev = $urandom_range(0, 1) ? '0 : {SB{1'b1}};
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern, compare every accepted direction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !stall_enable || ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    direction_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_dirs.size() == 0) begin
        $display("%0t: unexpected direction x=%0d y=%0d z=%0d", $time,
                 $signed(out_ch.dir_x), $signed(out_ch.dir_y), out_ch.dir_z);
        error_count++;
      end else begin
        want = pending_dirs.pop_front();
        if (out_ch.dir_x !== want.x) begin
          $display("%0t: dir_x expected %0d actual %0d", $time, $signed(want.x),
                   $signed(out_ch.dir_x));
          error_count++;
        end
        if (out_ch.dir_y !== want.y) begin
          $display("%0t: dir_y expected %0d actual %0d", $time, $signed(want.y),
                   $signed(out_ch.dir_y));
          error_count++;
        end
        if (out_ch.dir_z !== want.z) begin
          $display("%0t: dir_z expected %0d actual %0d", $time, want.z, out_ch.dir_z);
          error_count++;
        end
      end
    end
  end

  // Watchdog: count cycles without any handshake.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table: extremes, every quadrant, zero elevation, zero exponent.
  // ---------------------------------------------------------------------------
  stim_row_t directed_rows[$];

  function automatic stim_row_t mk_row(input logic [SB-1:0] e, input logic [SB-1:0] a,
                                       input logic [EB-1:0] n, input bit typed,
                                       input logic [OB-1:0] x, input logic [OB-1:0] y,
                                       input logic [OB-2:0] z);
    stim_row_t r;
    r.smp.elev = e;
    r.smp.azim = a;
    r.smp.expo = n;
    r.has_dir  = typed;
    r.dir.x = x;
    r.dir.y = y;
    r.dir.z = z;
    return r;
  endfunction

  initial begin
    sample_t smp;
    int unsigned burst;
    error_count  = 0;
    idle_cycles  = 0;
    stim_done    = 0;
    stall_enable = 0;
    rst_ni = 1'b0;
    in_ch.valid            = 1'b0;
    in_ch.elevation_sample = '0;
    in_ch.azimuth_sample   = '0;
    in_ch.lobe_exponent    = '0;

    // Zero elevation: z is 0 and sin(el) is 1, so x/y read straight off the angle.
    directed_rows.push_back(mk_row('0, '0, '0, 1, 16'sd32767, 16'sd0, '0));
    directed_rows.push_back(mk_row('0, 16'h4000, '0, 1, 16'sd0, 16'sd32767, '0));
    directed_rows.push_back(mk_row('0, 16'h8000, {EB{1'b1}}, 1, -16'sd32767, 16'sd0, '0));
    directed_rows.push_back(mk_row('0, 16'hC000, '0, 1, 16'sd0, -16'sd32767, '0));
    directed_rows.push_back(mk_row({SB{1'b1}}, '0, '0, 0, '0, '0, '0));
    directed_rows.push_back(mk_row({SB{1'b1}}, {SB{1'b1}}, {EB{1'b1}}, 0, '0, '0, '0));
    directed_rows.push_back(mk_row(16'h8000, 16'h2000, '0, 0, '0, '0, '0));
    directed_rows.push_back(mk_row(16'h0001, 16'h6000, 10'd1, 0, '0, '0, '0));
    directed_rows.push_back(mk_row(16'h0001, 16'hA000, {EB{1'b1}}, 0, '0, '0, '0));
    directed_rows.push_back(mk_row(16'h5555, 16'hE000, 10'h2AA, 0, '0, '0, '0));
    directed_rows.push_back(mk_row(16'hAAAA, 16'h3FFF, 10'h155, 0, '0, '0, '0));
    directed_rows.push_back(mk_row(16'hFFFE, 16'h7FFF, 10'd1023, 0, '0, '0, '0));
    directed_rows.push_back(mk_row(16'h0100, 16'hBFFF, 10'd7, 0, '0, '0, '0));
    directed_rows.push_back(mk_row(16'h1234, 16'h0001, 10'd32, 0, '0, '0, '0));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the table back to back, then turn on output stalls for random traffic.
    foreach (directed_rows[i])
      send_sample(directed_rows[i].smp, directed_rows[i].dir, directed_rows[i].has_dir);
    in_ch.valid <= 1'b0;
    stall_enable = 1;

    // Random bursts with random gaps; hold off around midway until fully drained.
    for (int unsigned k = 0; k < N_RANDOM; ) begin
      burst = $urandom_range(1, 40);
      for (int unsigned b = 0; b < burst && k < N_RANDOM; b++, k++) begin
        smp = random_sample();
        send_sample(smp, '0, 0);
      end
      if (k >= N_RANDOM / 2 && k < N_RANDOM / 2 + 40) begin
        in_ch.valid <= 1'b0;
        wait (pending_dirs.size() == 0);
        @(posedge clk_i);
      end else begin
        idle_gap($urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0);
      end
    end
    in_ch.valid <= 1'b0;
    stim_done = 1;

    wait (pending_dirs.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
